[hw/rtl/lsurng_pkg.sv]
// ----------------------------------------------------------------------------
// Lagged-subtract uniform generator: shared package
// Types, constants and small arithmetic helpers used by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package lsurng_pkg;

  // Table geometry and lag pointer start values.
  localparam int unsigned Lags = 97;
  localparam logic [6:0] PtrFirstStart = 7'd97;
  localparam logic [6:0] PtrSecondStart = 7'd33;
  localparam logic [6:0] PtrTop = 7'd97;

  // Carry sequence constants in 0.24 fixed point.
  localparam logic [23:0] CarryInit = 24'd362436;
  localparam logic [23:0] CarryDec = 24'd7654321;
  localparam logic [23:0] CarryWrapAdd = 24'd9122892;  // modulus minus decrement
  localparam logic [23:0] CarryMod = 24'd16777213;

  // Seed handling.
  localparam logic signed [31:0] SeedMax = 32'sd900000000;
  localparam logic [29:0] SeedDefault = 30'd100;

  // Seed split divisors and mixing moduli.
  localparam logic [14:0] DivSeed = 15'd30082;
  localparam logic [14:0] DivIj = 15'd177;
  localparam logic [14:0] DivKl = 15'd169;
  localparam logic [15:0] Mod179 = 16'd179;
  localparam logic [13:0] Mod169 = 14'd169;
  localparam logic [13:0] LcgMul = 14'd53;

  // Truncated reciprocals for the seed split. The 30-bit seed split uses a
  // 45-bit scale and the 15-bit splits a 23-bit scale, so each quotient
  // estimate is low by at most one and a single correction step finishes it.
  localparam int unsigned RecipSeedShift = 45;
  localparam int unsigned RecipSmallShift = 23;
  localparam logic [30:0] RecipSeed = 31'((64'd1 << RecipSeedShift) / 64'd30082);
  localparam logic [30:0] RecipIj = 31'((64'd1 << RecipSmallShift) / 64'd177);
  localparam logic [30:0] RecipKl = 31'((64'd1 << RecipSmallShift) / 64'd169);

  // Steps of one division, counted down by the controller.
  localparam logic [3:0] DivStepMul = 4'd2;
  localparam logic [3:0] DivStepSub = 4'd1;
  localparam logic [3:0] DivStepFix = 4'd0;

  // Sequencer limits.
  localparam logic [3:0] DivSeedTop = DivStepMul;
  localparam logic [3:0] DivSmallTop = DivStepMul;
  localparam logic [4:0] LastBit = 5'd23;
  localparam logic [6:0] LastRow = 7'(Lags - 1);

  // Controller states.
  typedef enum logic [4:0] {
    ST_RESET,
    ST_IDLE,
    ST_DIV_A,
    ST_SAVE_A,
    ST_DIV_B,
    ST_SAVE_B,
    ST_DIV_C,
    ST_SAVE_C,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_MIX4,
    ST_MIX5,
    ST_STORE,
    ST_DRAW_RD,
    ST_DRAW_WR
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_SEED,
    DP_DIV,
    DP_SAVE_A,
    DP_SAVE_B,
    DP_SAVE_C,
    DP_MIX1,
    DP_MIX2,
    DP_MIX3,
    DP_MIX4,
    DP_MIX5,
    DP_STORE,
    DP_DRAW
  } dp_op_t;

  // Divisor selection for the shared reciprocal divider.
  typedef enum logic [1:0] {
    DIV_SEL_SEED,
    DIV_SEL_IJ,
    DIV_SEL_KL
  } div_sel_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t     op;
    div_sel_t   div_sel;
    logic [3:0] bit_idx;
    logic [6:0] row;
    logic       use_default;
    logic       respond;
    logic       zero_value;
  } dp_cmd_t;

  // Input item and result item.
  typedef struct packed {
    logic              operation;
    logic signed [31:0] seed;
  } rng_in_t;

  typedef struct packed {
    logic [23:0] value;
    logic [29:0] seed_used;
  } rng_out_t;

  // Remainder modulo 179 of a product of two values below 179.
  // Quotient stays below 256, so eight compare-subtract steps suffice.
  function automatic logic [7:0] mod179(input logic [14:0] x);
    logic [15:0] r;
    r = {1'b0, x};
    for (int b = 7; b >= 0; b--) begin
      if (r >= (Mod179 << b)) begin
        r = r - (Mod179 << b);
      end
    end
    return r[7:0];
  endfunction

  // Remainder modulo 169 of 53*l+1 with l below 169 (quotient below 64).
  function automatic logic [7:0] mod169(input logic [13:0] x);
    logic [13:0] r;
    r = x;
    for (int b = 5; b >= 0; b--) begin
      if (r >= (Mod169 << b)) begin
        r = r - (Mod169 << b);
      end
    end
    return r[7:0];
  endfunction

endpackage

[hw/rtl/lsurng_ctrl.sv]
// ----------------------------------------------------------------------------
// Lagged-subtract uniform generator: controller
// Sequences seed splitting, table fill, the discarded draw and normal draws,
// and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module lsurng_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  output logic              busy,
  output lsurng_pkg::dp_cmd_t cmd
);
  import lsurng_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [3:0] dcnt;
  logic [4:0] bit_cnt;
  logic [6:0] row_cnt;
  logic       init_mode;
  logic       silent;
  logic       accept;

  assign accept = start && (state == ST_IDLE);
  assign busy = (state != ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_RESET:   state_next = ST_DIV_A;
      ST_IDLE: begin
        if (start) begin
          state_next = operation ? ST_DIV_A : ST_DRAW_WR;
        end
      end
      ST_DIV_A:   state_next = (dcnt == '0) ? ST_SAVE_A : ST_DIV_A;
      ST_SAVE_A:  state_next = ST_DIV_B;
      ST_DIV_B:   state_next = (dcnt == '0) ? ST_SAVE_B : ST_DIV_B;
      ST_SAVE_B:  state_next = ST_DIV_C;
      ST_DIV_C:   state_next = (dcnt == '0) ? ST_SAVE_C : ST_DIV_C;
      ST_SAVE_C:  state_next = ST_MIX1;
      ST_MIX1:    state_next = ST_MIX2;
      ST_MIX2:    state_next = ST_MIX3;
      ST_MIX3:    state_next = ST_MIX4;
      ST_MIX4:    state_next = ST_MIX5;
      ST_MIX5:    state_next = (bit_cnt == LastBit) ? ST_STORE : ST_MIX1;
      ST_STORE:   state_next = (row_cnt == LastRow) ? ST_DRAW_RD : ST_MIX1;
      ST_DRAW_RD: state_next = ST_DRAW_WR;
      ST_DRAW_WR: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    cmd.op = DP_NOP;
    cmd.div_sel = DIV_SEL_SEED;
    cmd.bit_idx = dcnt;
    cmd.row = row_cnt;
    cmd.respond = !silent;
    cmd.zero_value = init_mode;
    case (state)
      ST_RESET: begin
        cmd.op = DP_SEED;
        cmd.use_default = 1'b1;
      end
      ST_IDLE: begin
        if (start && operation) begin
          cmd.op = DP_SEED;
        end
      end
      ST_DIV_A: begin
        cmd.op = DP_DIV;
        cmd.div_sel = DIV_SEL_SEED;
      end
      ST_SAVE_A:  cmd.op = DP_SAVE_A;
      ST_DIV_B: begin
        cmd.op = DP_DIV;
        cmd.div_sel = DIV_SEL_IJ;
      end
      ST_SAVE_B:  cmd.op = DP_SAVE_B;
      ST_DIV_C: begin
        cmd.op = DP_DIV;
        cmd.div_sel = DIV_SEL_KL;
      end
      ST_SAVE_C:  cmd.op = DP_SAVE_C;
      ST_MIX1:    cmd.op = DP_MIX1;
      ST_MIX2:    cmd.op = DP_MIX2;
      ST_MIX3:    cmd.op = DP_MIX3;
      ST_MIX4:    cmd.op = DP_MIX4;
      ST_MIX5:    cmd.op = DP_MIX5;
      ST_STORE:   cmd.op = DP_STORE;
      ST_DRAW_RD: cmd.op = DP_NOP;
      ST_DRAW_WR: cmd.op = DP_DRAW;
      default:    cmd.op = DP_NOP;
    endcase
  end

  // State register and sequencing counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RESET;
      dcnt <= '0;
      bit_cnt <= '0;
      row_cnt <= '0;
      init_mode <= 1'b1;
      silent <= 1'b1;
    end else begin
      state <= state_next;
      case (state)
        ST_RESET: begin
          dcnt <= DivSeedTop;
          init_mode <= 1'b1;
          silent <= 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            init_mode <= operation;
            silent <= 1'b0;
            dcnt <= DivSeedTop;
          end
        end
        ST_DIV_A, ST_DIV_B, ST_DIV_C: begin
          if (dcnt != '0) begin
            dcnt <= dcnt - 4'd1;
          end
        end
        ST_SAVE_A, ST_SAVE_B: begin
          dcnt <= DivSmallTop;
        end
        ST_SAVE_C: begin
          bit_cnt <= '0;
          row_cnt <= '0;
        end
        ST_MIX5: begin
          bit_cnt <= (bit_cnt == LastBit) ? '0 : bit_cnt + 5'd1;
        end
        ST_STORE: begin
          if (row_cnt != LastRow) begin
            row_cnt <= row_cnt + 7'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // An accepted item always occupies the block for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A table row is written only once all 24 of its bits are assembled.
  assert property (@(posedge clk) disable iff (rst) (state == ST_STORE) |-> (bit_cnt == '0))
    else $error("row store with partial bit count");

endmodule

[hw/rtl/lsurng_dp.sv]
// ----------------------------------------------------------------------------
// Lagged-subtract uniform generator: datapath
// Holds the 97-entry lag table, the lag pointers, the carry term, the seed
// divider and the mixing registers, and forms the result item.
// ----------------------------------------------------------------------------
module lsurng_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  lsurng_pkg::dp_cmd_t  cmd,
  input  logic signed [31:0]   seed,
  output lsurng_pkg::rng_out_t result,
  output logic                 done
);
  import lsurng_pkg::*;

  // Lag table with one write port and two registered read ports.
  logic [23:0] lag_mem [Lags];
  logic [23:0] rd_a;
  logic [23:0] rd_b;
  logic        wr_en;
  logic [6:0]  wr_addr;
  logic [23:0] wr_data;

  // Generator state.
  logic [6:0]  ptr_a;
  logic [6:0]  ptr_b;
  logic [23:0] carry;
  logic [29:0] active_seed;
  logic [23:0] draw_value;

  // Seed divider.
  logic [29:0] rem;
  logic [14:0] quo;
  logic [14:0] kl;
  logic [14:0] divisor;
  logic [30:0] recip;
  logic [60:0] dprod;
  logic [14:0] qest;
  logic [29:0] qprod;

  // Mixing registers.
  logic [7:0]  mi;
  logic [7:0]  mj;
  logic [7:0]  mk;
  logic [7:0]  ml;
  logic [7:0]  mm;
  logic [7:0]  pm;
  logic [14:0] prod;
  logic [13:0] lprod;
  logic [23:0] acc;
  logic [11:0] lm_prod;

  // Draw arithmetic.
  logic [23:0] diff;
  logic [23:0] carry_next;
  logic        seed_ok;
  logic [29:0] seed_eff;

  // Seed validation.
  always_comb begin
    seed_ok = (seed > 32'sd0) && (seed <= SeedMax);
    if (cmd.use_default || !seed_ok) begin
      seed_eff = SeedDefault;
    end else begin
      seed_eff = seed[29:0];
    end
  end

  // Divisor, reciprocal and quotient estimate for the selected split.
  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_SEED: begin
        divisor = DivSeed;
        recip = RecipSeed;
        qest = dprod[RecipSeedShift +: 15];
      end
      DIV_SEL_IJ: begin
        divisor = DivIj;
        recip = RecipIj;
        qest = dprod[RecipSmallShift +: 15];
      end
      DIV_SEL_KL: begin
        divisor = DivKl;
        recip = RecipKl;
        qest = dprod[RecipSmallShift +: 15];
      end
      default: begin
        divisor = DivSeed;
        recip = RecipSeed;
        qest = dprod[RecipSeedShift +: 15];
      end
    endcase
    qprod = {15'd0, qest} * {15'd0, divisor};
  end

  // Low six bits of l*m decide each table bit.
  assign lm_prod = {6'd0, ml[5:0]} * {6'd0, mm[5:0]};

  // Lagged difference and carry step.
  always_comb begin
    diff = rd_a - rd_b;
    if (carry < CarryDec) begin
      carry_next = carry + CarryWrapAdd;
    end else begin
      carry_next = carry - CarryDec;
    end
  end

  // Table write port selection.
  always_comb begin
    wr_en = (cmd.op == DP_STORE) || (cmd.op == DP_DRAW);
    if (cmd.op == DP_STORE) begin
      wr_addr = cmd.row;
      wr_data = acc;
    end else begin
      wr_addr = ptr_a - 7'd1;
      wr_data = diff;
    end
  end

  // Lag table memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lag_mem[wr_addr] <= wr_data;
    end
    rd_a <= lag_mem[ptr_a - 7'd1];
    rd_b <= lag_mem[ptr_b - 7'd1];
  end

  // Seed split and mixing registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_SEED: begin
        rem <= seed_eff - 30'd1;
        quo <= '0;
      end
      DP_DIV: begin
        // Multiply by the reciprocal, take the estimate, then correct by one.
        case (cmd.bit_idx)
          DivStepMul: begin
            dprod <= 61'(rem) * 61'(recip);
          end
          DivStepSub: begin
            quo <= qest;
            rem <= rem - qprod;
          end
          DivStepFix: begin
            if (rem >= {15'd0, divisor}) begin
              rem <= rem - {15'd0, divisor};
              quo <= quo + 15'd1;
            end
          end
          default: begin
          end
        endcase
      end
      DP_SAVE_A: begin
        kl <= rem[14:0];
        rem <= {15'd0, quo};
        quo <= '0;
      end
      DP_SAVE_B: begin
        mi <= quo[7:0] + 8'd2;
        mj <= rem[7:0] + 8'd2;
        rem <= {15'd0, kl};
        quo <= '0;
      end
      DP_SAVE_C: begin
        mk <= quo[7:0] + 8'd1;
        ml <= rem[7:0];
      end
      DP_MIX1: begin
        prod <= 15'({8'd0, mi} * {8'd0, mj});
        lprod <= 14'(14'(ml) * LcgMul + 14'd1);
      end
      DP_MIX2: begin
        pm <= mod179(prod);
        ml <= mod169(lprod);
      end
      DP_MIX3: begin
        prod <= 15'({8'd0, pm} * {8'd0, mk});
      end
      DP_MIX4: begin
        mm <= mod179(prod);
        mi <= mj;
        mj <= mk;
        mk <= mod179(prod);
      end
      DP_MIX5: begin
        acc <= {acc[22:0], lm_prod[5]};
      end
      default: begin
      end
    endcase
  end

  // Generator state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_a <= PtrFirstStart;
      ptr_b <= PtrSecondStart;
      carry <= CarryInit;
      active_seed <= SeedDefault;
      done <= 1'b0;
      draw_value <= '0;
    end else begin
      done <= 1'b0;
      case (cmd.op)
        DP_SEED: begin
          active_seed <= seed_eff;
        end
        DP_SAVE_C: begin
          carry <= CarryInit;
          ptr_a <= PtrFirstStart;
          ptr_b <= PtrSecondStart;
        end
        DP_DRAW: begin
          carry <= carry_next;
          ptr_a <= (ptr_a == 7'd1) ? PtrTop : ptr_a - 7'd1;
          ptr_b <= (ptr_b == 7'd1) ? PtrTop : ptr_b - 7'd1;
          done <= cmd.respond;
          draw_value <= cmd.zero_value ? '0 : diff - carry_next;
        end
        default: begin
        end
      endcase
    end
  end

  assign result = {draw_value, active_seed};

  // The two lag pointers always stay 64 apart around the 97-entry ring.
  assert property (@(posedge clk) disable iff (rst)
    (ptr_a == ptr_b + 7'd64) || (ptr_a + 7'd33 == ptr_b))
    else $error("lag pointer spacing lost");

  // The carry term stays below its modulus.
  assert property (@(posedge clk) disable iff (rst) carry < CarryMod)
    else $error("carry term out of range");

  // A result is shown only after a draw step that was told to respond.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.op == DP_DRAW && cmd.respond))
    else $error("result strobe without a draw");

endmodule

[hw/rtl/lagged_subtract_uniform_rng_top.sv]
// ----------------------------------------------------------------------------
// Lagged-subtract uniform generator: top level
// 24-bit subtractive lagged generator with a seeded table fill.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; each item gives one
// result, shown on result for a single cycle with done high, in the same
// cycle in which busy falls, and the receiver must take it then. A draw
// (operation 0) passes from acceptance through the draw-write state to the
// result. An init (operation 1) first splits the seed with a shared
// reciprocal-multiply divider, then runs each of the 2328 table bits through
// the multiply and modulo states MIX1 to MIX5, with one table write per 24
// bits, and ends with a discarded draw. After reset the block runs the same
// init with seed 100 without giving a result, and busy is high for that time.
// ----------------------------------------------------------------------------
module lagged_subtract_uniform_rng_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lsurng_pkg::rng_in_t  command,
  output logic                 busy,
  output logic                 done,
  output lsurng_pkg::rng_out_t result
);
  import lsurng_pkg::*;

  dp_cmd_t cmd;

  // Sequencer.
  lsurng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (command.operation),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Table, divider and mixing datapath.
  lsurng_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .seed   (command.seed),
    .result (result),
    .done   (done)
  );

endmodule
